// ===== hw/rtl/ptud_pkg.sv =====
// ptud_pkg: shared types, codes and palette conversion for the palettized
// texture unswizzle decoder
// no dependencies
package ptud_pkg;

    localparam int PALETTE_ENTRIES   = 256;
    localparam int SUBTEXTURE_PIXELS = 8192;
    localparam int SLOT_W            = $clog2(PALETTE_ENTRIES);
    localparam int PIX_ADDR_W        = $clog2(SUBTEXTURE_PIXELS);
    localparam int COLOUR_W          = 32;

    // input commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // configuration register indexes
    localparam logic REG_PALETTE_IS_32BIT = 1'b0;
    localparam logic REG_LAYOUT_SWIZZLED  = 1'b1;

    // controls for the swizzle address generator
    typedef struct packed {
        logic advance;
        logic clear;
    } ptud_gen_ctrl_t;

    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [COLOUR_W-1:0] convert_word(input logic [31:0] w,
                                                         input logic is_32bit);
        logic [COLOUR_W-1:0] c;
        if (is_32bit) begin
            c = {w[31:24], w[7:0], w[15:8], w[23:16]};
        end else begin
            c = {(w[15] ? 8'h80 : 8'h00), widen5(w[4:0]), widen5(w[9:5]),
                 widen5(w[14:10])};
        end
        return c;
    endfunction

    // clut reorder: swap bits 3 and 4 of the load position
    function automatic logic [SLOT_W-1:0] clut_slot(input logic [SLOT_W-1:0] k);
        logic [SLOT_W-1:0] s;
        s    = k;
        s[3] = k[4];
        s[4] = k[3];
        return s;
    endfunction

endpackage

// ===== hw/rtl/ptud_clut_ram.sv =====
// ptud_clut_ram: colour table memory, one write and one registered read port
// depends on ptud_pkg
module ptud_clut_ram (
    input  logic                              aclk,
    input  logic                              wr_en,
    input  logic [ptud_pkg::SLOT_W-1:0]       wr_addr,
    input  logic [ptud_pkg::COLOUR_W-1:0]     wr_data,
    input  logic                              rd_en,
    input  logic [ptud_pkg::SLOT_W-1:0]       rd_addr,
    output logic [ptud_pkg::COLOUR_W-1:0]     rd_data
);
    import ptud_pkg::*;

    logic [COLOUR_W-1:0] table_mem_reg [PALETTE_ENTRIES];
    logic [COLOUR_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= table_mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/ptud_swizzle_gen.sv =====
// ptud_swizzle_gen: incremental swizzle address generator for 128x64 subtextures
// depends on ptud_pkg
module ptud_swizzle_gen (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  ptud_pkg::ptud_gen_ctrl_t           ctrl,
    output logic [ptud_pkg::PIX_ADDR_W-1:0]    swz_address
);
    import ptud_pkg::*;

    localparam logic signed [5:0] SHIFT_LOW  = 6'sd12;
    localparam logic signed [5:0] SHIFT_HIGH = 6'sd16;

    logic [13:0]        base_reg, base_next;
    logic [4:0]         step_reg, step_next;
    logic signed [5:0]  shift_reg, shift_next;

    logic               upper;
    logic signed [5:0]  off;
    logic signed [4:0]  bonus;
    logic [13:0]        base_inc;

    always_comb begin
        upper = base_reg[9];
        off   = shift_reg + 6'sd3;
        if (step_reg[1:0] == 2'd0) begin
            off = off - 6'sd15;
        end
        bonus = 5'sd0;
        if (step_reg > 5'd16 && !upper && step_reg[0]) begin
            bonus = -5'sd8;
        end
        if (!(step_reg < 5'd16 && !step_reg[0]) && upper) begin
            bonus = -5'sd8;
        end
        swz_address = base_reg[PIX_ADDR_W-1:0]
                    + {{(PIX_ADDR_W-5){1'b0}}, step_reg}
                    + {{(PIX_ADDR_W-9){1'b0}}, step_reg[0], 8'h00}
                    + {{(PIX_ADDR_W-6){off[5]}}, off}
                    + {{(PIX_ADDR_W-5){bonus[4]}}, bonus};
    end

    always_comb begin
        base_next  = base_reg;
        step_next  = step_reg;
        shift_next = shift_reg;
        base_inc   = base_reg + 14'd16;
        if (ctrl.clear) begin
            base_next  = '0;
            step_next  = '0;
            shift_next = SHIFT_LOW;
        end else if (ctrl.advance) begin
            step_next  = step_reg + 5'd1;
            shift_next = off;
            if (step_reg == 5'd31) begin
                // end of a 32-pixel run: move to the next column block
                base_next  = (base_inc[7:0] == 8'h00) ? base_inc + 14'd256 : base_inc;
                shift_next = base_next[9] ? SHIFT_HIGH : SHIFT_LOW;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= '0;
            step_reg  <= '0;
            shift_reg <= SHIFT_LOW;
        end else begin
            base_reg  <= base_next;
            step_reg  <= step_next;
            shift_reg <= shift_next;
        end
    end

endmodule

// ===== hw/rtl/palettized_texture_unswizzle_decode.sv =====
// palettized_texture_unswizzle_decode: top level of the palettized texture decoder
// depends on ptud_pkg, ptud_clut_ram, ptud_swizzle_gen
//
// Takes one transfer per clock. A transfer with s_cmd low loads the next palette
// word into the colour table (bits 3 and 4 of its slot swapped, converted to
// ARGB32 with the mode in force) and gives no result. A transfer with s_cmd high
// is a pixel: its colour is read from the table and its subtexture address
// comes from the swizzle generator, or is linear when layout_swizzled is 0. The
// result passes through the registered colour table read and the output register
// before it appears on the m_ channel. Sustained rate is one item per cycle;
// s_ready drops only when both the read stage and the output register hold
// results that m_ready has not taken. The palette must be loaded before pixels
// that use it; unwritten entries read as arbitrary data. Configuration is
// written through cfg_we/cfg_index/cfg_wdata; the user must write it only while
// the block is idle, which the block itself does not enforce.
module palettized_texture_unswizzle_decode (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic                               cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_cmd,
    input  logic [31:0]                        s_palette_word,
    input  logic [7:0]                         s_pixel_index,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [12:0]                        m_pixel_address,
    output logic [31:0]                        m_pixel_colour,
    output logic                               m_last_of_subtexture
);
    import ptud_pkg::*;

    logic                    palette_32_reg;
    logic                    layout_swz_reg;
    logic [SLOT_W-1:0]       load_pos_reg;
    logic [PIX_ADDR_W-1:0]   pixel_pos_reg;

    logic                    s1_valid_reg, s1_valid_next;
    logic [PIX_ADDR_W-1:0]   s1_addr_reg;
    logic                    s1_last_reg;

    logic                    out_valid_reg, out_valid_next;
    logic [PIX_ADDR_W-1:0]   out_addr_reg;
    logic [COLOUR_W-1:0]     out_colour_reg;
    logic                    out_last_reg;

    logic                    s_xfer, load_xfer, pixel_xfer, advance, last_pixel;
    logic [PIX_ADDR_W-1:0]   swz_address;
    logic [COLOUR_W-1:0]     rd_data;
    ptud_gen_ctrl_t          gen_ctrl;

    assign s_xfer     = s_valid && s_ready;
    assign load_xfer  = s_xfer && (s_cmd == CMD_LOAD);
    assign pixel_xfer = s_xfer && (s_cmd == CMD_PIXEL);
    assign last_pixel = (pixel_pos_reg == PIX_ADDR_W'(SUBTEXTURE_PIXELS - 1));

    // read stage moves into the output register when that is free or drained
    assign advance = s1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || !out_valid_reg || m_ready;

    assign gen_ctrl.advance = pixel_xfer;
    assign gen_ctrl.clear   = pixel_xfer && last_pixel;

    ptud_clut_ram u_clut_ram (
        .aclk    (aclk),
        .wr_en   (load_xfer),
        .wr_addr (clut_slot(load_pos_reg)),
        .wr_data (convert_word(s_palette_word, palette_32_reg)),
        .rd_en   (pixel_xfer),
        .rd_addr (s_pixel_index),
        .rd_data (rd_data)
    );

    ptud_swizzle_gen u_swizzle_gen (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (gen_ctrl),
        .swz_address (swz_address)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (pixel_xfer) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            palette_32_reg <= 1'b0;
            layout_swz_reg <= 1'b1;
            load_pos_reg   <= '0;
            pixel_pos_reg  <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_PALETTE_IS_32BIT: palette_32_reg <= cfg_wdata;
                    REG_LAYOUT_SWIZZLED:  layout_swz_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (load_xfer) begin
                load_pos_reg <= load_pos_reg + SLOT_W'(1);
            end
            if (pixel_xfer) begin
                pixel_pos_reg <= pixel_pos_reg + PIX_ADDR_W'(1);
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pixel_xfer) begin
            s1_addr_reg <= layout_swz_reg ? swz_address : pixel_pos_reg;
            s1_last_reg <= last_pixel;
        end
        if (advance) begin
            out_addr_reg   <= s1_addr_reg;
            out_colour_reg <= rd_data;
            out_last_reg   <= s1_last_reg;
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_pixel_address      = out_addr_reg;
    assign m_pixel_colour       = out_colour_reg;
    assign m_last_of_subtexture = out_last_reg;

endmodule

// ===== hw/rtl/ptud_checker.sv =====
// ptud_checker: port-level assertions for palettized_texture_unswizzle_decode
// bound to the top level; depends only on its ports
module ptud_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_cmd,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [12:0] m_pixel_address,
    input  logic [31:0] m_pixel_colour,
    input  logic        m_last_of_subtexture
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_address)
            && $stable(m_pixel_colour) && $stable(m_last_of_subtexture))
        else $error("stalled result changed");

    // a new result comes only from a pixel transfer that passed through the read stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_cmd, 2))
        else $error("result without pixel transfer");

    // input stalls only while the output side is blocked
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled with free output");

    // nothing is shown right after reset
    assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid after reset");

endmodule

bind palettized_texture_unswizzle_decode ptud_checker u_ptud_checker (
    .aclk                 (aclk),
    .aresetn              (aresetn),
    .s_valid              (s_valid),
    .s_ready              (s_ready),
    .s_cmd                (s_cmd),
    .m_valid              (m_valid),
    .m_ready              (m_ready),
    .m_pixel_address      (m_pixel_address),
    .m_pixel_colour       (m_pixel_colour),
    .m_last_of_subtexture (m_last_of_subtexture)
);
